// ----- src/zone_mean_centroid_distance_defines.svh -----
// Assertion macros for the zone mean centroid distance block
`ifndef ZONE_MEAN_CENTROID_DISTANCE_DEFINES_SVH
`define ZONE_MEAN_CENTROID_DISTANCE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ZMCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ZMCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZMCD_ASSERT(label, prop, msg)
`define ZMCD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- src/zmcd_pkg.sv -----
// Constants and codes for the zone mean centroid distance block
`timescale 1ns / 1ps
package zmcd_pkg;

  localparam int IMAGE_SIDE    = 1024;
  localparam int FRACTION_BITS = 8;

  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;
  localparam int BOUND_W = 11;
  localparam int SUM_W   = 40;
  localparam int COUNT_W = 21;
  localparam int MEAN_W  = 19;

  localparam int SQ_W     = 2 * COORD_W + 1;
  localparam int RAD_W    = SQ_W + 2 * FRACTION_BITS;
  localparam int RAD_PAD  = RAD_W + (RAD_W % 2);
  localparam int ROOT_W   = RAD_PAD / 2;
  localparam int REM_W    = (ROOT_W + 2 > COUNT_W) ? ROOT_W + 2 : COUNT_W;
  localparam int TRIAL_W  = REM_W + 2;
  localparam int ITER_W   = $clog2(ROOT_W);

  localparam int IN_W  = 32;
  localparam int OUT_W = 40;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_ROW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_COL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_ROW_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_ROW_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COL_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COL_END   = 3'd5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE  = 3'd0;
  localparam state_t ST_SQ1   = 3'd1;
  localparam state_t ST_SQ2   = 3'd2;
  localparam state_t ST_ROOT  = 3'd3;
  localparam state_t ST_ACC   = 3'd4;
  localparam state_t ST_DINIT = 3'd5;
  localparam state_t ST_DIV   = 3'd6;
  localparam state_t ST_OUT   = 3'd7;

endpackage

// ----- src/zone_mean_centroid_distance.sv -----
// Top level: zone mean distance of black pixels to a centroid
//
// Pixels arrive on the s_ group, one request per pixel; tlast marks the final
// pixel of a scan. A black pixel inside the zone has its distance to the
// centroid computed as an exact floor square root in Q11.8 and added to a
// running sum. On the last pixel the mean (sum / count, or 0 for no pixels)
// and the count are sent as one request on the m_ group, and the sums clear.
// Per pixel: a pixel that does not count leaves the sequencer idle unless it is
// last; a counted pixel takes two squaring steps on the one multiplier and the
// 19 iterations of the shared subtract-compare unit for the root, then the sum.
// A last pixel adds the division on the same unit.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it, and
// the sequencer only waits if a second result is ready before the first goes.
// Reset clears the sums, the sequencer and the output valid, and loads the
// default zone and centroid. cfg_* writes take effect at once while idle.
`timescale 1ns / 1ps
`include "zone_mean_centroid_distance_defines.svh"
module zone_mean_centroid_distance (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [zmcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [zmcd_pkg::BOUND_W-1:0]       cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pixel_row [9:0], pixel_col [19:10], pixel_value [27:20], zero [31:28]
  input  logic [zmcd_pkg::IN_W-1:0]          s_tdata,
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // mean_distance [18:0], black_count [39:19]
  output logic [zmcd_pkg::OUT_W-1:0]         m_tdata
);
  import zmcd_pkg::*;

  logic [COORD_W-1:0] centroid_row, centroid_col, zone_row_start, zone_col_start;
  logic [BOUND_W-1:0] zone_row_end, zone_col_end;

  state_t             state;
  logic [COORD_W-1:0] dr, dc;
  logic               last;
  logic [SQ_W-1:0]    sq;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  quo;
  logic [RAD_PAD-1:0] shreg;
  logic [ITER_W-1:0]  iter;
  logic [SUM_W-1:0]   distance_sum;
  logic [COUNT_W-1:0] black_total;

  logic [COORD_W-1:0] in_row, in_col;
  logic [PIX_W-1:0]   in_val;
  logic               accept, counted;
  logic [COORD_W-1:0] mult_op;
  logic [2*COORD_W-1:0] prod;
  logic [TRIAL_W-1:0] trial_a, trial_b;
  logic [TRIAL_W:0]   diff;
  logic               fits;
  logic [SUM_W:0]     sum_add;

  assign in_row = s_tdata[COORD_W-1:0];
  assign in_col = s_tdata[2*COORD_W-1:COORD_W];
  assign in_val = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign counted = (in_val == '0) && (int'(in_row) < IMAGE_SIDE) &&
                   (int'(in_col) < IMAGE_SIDE) &&
                   (in_row >= zone_row_start) && (BOUND_W'(in_row) < zone_row_end) &&
                   (in_col >= zone_col_start) && (BOUND_W'(in_col) < zone_col_end) &&
                   (black_total < COUNT_MAX);

  assign mult_op = (state == ST_SQ1) ? dr : dc;
  assign prod    = mult_op * mult_op;

  always_comb begin
    if (state == ST_DIV) begin
      trial_a = TRIAL_W'({rem, shreg[RAD_PAD-1]});
      trial_b = TRIAL_W'(black_total);
    end else begin
      trial_a = TRIAL_W'({rem, shreg[RAD_PAD-1 -: 2]});
      trial_b = TRIAL_W'({quo, 2'b01});
    end
  end

  assign diff    = {1'b0, trial_a} - {1'b0, trial_b};
  assign fits    = !diff[TRIAL_W];
  assign sum_add = {1'b0, distance_sum} + (SUM_W+1)'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      centroid_row   <= '0;
      centroid_col   <= '0;
      zone_row_start <= '0;
      zone_row_end   <= BOUND_W'(10);
      zone_col_start <= '0;
      zone_col_end   <= BOUND_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTROID_ROW:   centroid_row   <= cfg_data[COORD_W-1:0];
        REG_CENTROID_COL:   centroid_col   <= cfg_data[COORD_W-1:0];
        REG_ZONE_ROW_START: zone_row_start <= cfg_data[COORD_W-1:0];
        REG_ZONE_ROW_END:   zone_row_end   <= cfg_data;
        REG_ZONE_COL_START: zone_col_start <= cfg_data[COORD_W-1:0];
        REG_ZONE_COL_END:   zone_col_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      distance_sum <= '0;
      black_total  <= '0;
      m_tvalid     <= 1'b0;
      iter         <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            dr   <= (in_row > centroid_row) ? in_row - centroid_row : centroid_row - in_row;
            dc   <= (in_col > centroid_col) ? in_col - centroid_col : centroid_col - in_col;
            last <= s_tlast;
            if (counted) begin
              state <= ST_SQ1;
            end else if (s_tlast) begin
              state <= ST_DINIT;
            end
          end
        end
        ST_SQ1: begin
          sq    <= SQ_W'(prod);
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          shreg <= RAD_PAD'(sq + SQ_W'(prod)) << (2 * FRACTION_BITS);
          rem   <= '0;
          quo   <= '0;
          iter  <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          rem   <= fits ? diff[REM_W-1:0] : trial_a[REM_W-1:0];
          quo   <= {quo[ROOT_W-2:0], fits};
          shreg <= shreg << 2;
          iter  <= iter + 1'b1;
          if (iter == ITER_W'(ROOT_W - 1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          distance_sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          black_total  <= black_total + 1'b1;
          state        <= last ? ST_DINIT : ST_IDLE;
        end
        ST_DINIT: begin
          rem   <= REM_W'(distance_sum >> ROOT_W);
          shreg <= RAD_PAD'({distance_sum[ROOT_W-1:0], {(RAD_PAD-ROOT_W){1'b0}}});
          quo   <= '0;
          iter  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem   <= fits ? diff[REM_W-1:0] : trial_a[REM_W-1:0];
          quo   <= {quo[ROOT_W-2:0], fits};
          shreg <= shreg << 1;
          iter  <= iter + 1'b1;
          if (iter == ITER_W'(ROOT_W - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata[MEAN_W-1:0]              <= (black_total == '0) ? '0 : MEAN_W'(quo);
            m_tdata[MEAN_W+COUNT_W-1:MEAN_W] <= black_total;
            m_tvalid     <= 1'b1;
            distance_sum <= '0;
            black_total  <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ZMCD_ASSERT(a_result_from_out, $rose(m_tvalid) |-> $past(state) == ST_OUT, "result without division")
  `ZMCD_ASSERT(a_clear_after_result, $rose(m_tvalid) |-> black_total == '0 && distance_sum == '0, "sums not cleared")
  `ZMCD_ASSERT(a_empty_mean_zero, m_tvalid && m_tdata[MEAN_W+COUNT_W-1:MEAN_W] == '0 |-> m_tdata[MEAN_W-1:0] == '0, "mean of empty scan not zero")
  `ZMCD_ASSERT_ALWAYS(a_reset_idle, !rst && $past(rst) |-> state == ST_IDLE && !m_tvalid, "not idle after reset")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the zone mean centroid distance block
`timescale 1ns / 1ps
module tb;
  import zmcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 95;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   value;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
  } result_t;

  typedef struct packed {
    bit                 reconf;
    logic [BOUND_W-1:0] cr;
    logic [BOUND_W-1:0] cc;
    logic [BOUND_W-1:0] rs;
    logic [BOUND_W-1:0] re;
    logic [BOUND_W-1:0] cs;
    logic [BOUND_W-1:0] ce;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   value;
    logic               last;
    bit                 typed;
    logic [MEAN_W-1:0]  mean;
    logic [COUNT_W-1:0] count;
  } directed_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BOUND_W-1:0]   cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  // shadow of the block's registers and accumulators
  logic [COORD_W-1:0] cen_row = '0;
  logic [COORD_W-1:0] cen_col = '0;
  logic [COORD_W-1:0] zr_start = '0;
  logic [BOUND_W-1:0] zr_end = 11'd10;
  logic [COORD_W-1:0] zc_start = '0;
  logic [BOUND_W-1:0] zc_end = 11'd10;
  logic [SUM_W-1:0]   dist_sum = '0;
  logic [COUNT_W-1:0] black_total = '0;

  result_t     pending_results[$];
  int unsigned fail_count = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int          hold_left = 0;

  zone_mean_centroid_distance dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem = x;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic accumulate_distance(input pixel_t px, output bit emits, output result_t res);
    logic [63:0] dr;
    logic [63:0] dc;
    logic [63:0] d;
    logic [63:0] mean64;
    bit          in_zone;
    bit          counted;
    in_zone = px.row >= zr_start && {1'b0, px.row} < zr_end &&
              px.col >= zc_start && {1'b0, px.col} < zc_end;
    counted = px.value == '0 && in_zone && black_total != COUNT_MAX;
    if (counted) begin
      dr = (px.row > cen_row) ? 64'(px.row) - 64'(cen_row) : 64'(cen_row) - 64'(px.row);
      dc = (px.col > cen_col) ? 64'(px.col) - 64'(cen_col) : 64'(cen_col) - 64'(px.col);
      d = floor_root((dr * dr + dc * dc) << (2 * FRACTION_BITS));
      if (d > 64'(SUM_MAX) - 64'(dist_sum)) dist_sum = SUM_MAX;
      else dist_sum = SUM_W'(64'(dist_sum) + d);
      black_total = black_total + 21'd1;
    end
    emits = px.last;
    res = '0;
    if (emits) begin
      mean64 = (black_total != '0) ? 64'(dist_sum) / 64'(black_total) : 64'd0;
      res.mean = mean64[MEAN_W-1:0];
      res.count = black_total;
      dist_sum = '0;
      black_total = '0;
    end
  endtask

  task automatic send_pixel(input pixel_t px);
    while (send_idle && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, px.value, px.col, px.row};
    s_tlast <= px.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic issue_pixel(input pixel_t px);
    bit      emits;
    result_t res;
    send_pixel(px);
    accumulate_distance(px, emits, res);
    if (emits) pending_results.push_back(res);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_CENTROID_ROW:   cen_row = val[COORD_W-1:0];
      REG_CENTROID_COL:   cen_col = val[COORD_W-1:0];
      REG_ZONE_ROW_START: zr_start = val[COORD_W-1:0];
      REG_ZONE_ROW_END:   zr_end = val;
      REG_ZONE_COL_START: zc_start = val[COORD_W-1:0];
      REG_ZONE_COL_END:   zc_end = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [BOUND_W-1:0] cr, cc, rs, re, cs, ce);
    write_reg(($urandom_range(1) != 0) ? REG_UNUSED_A : REG_UNUSED_B, BOUND_W'($urandom));
    write_reg(REG_CENTROID_ROW, cr);
    write_reg(REG_CENTROID_COL, cc);
    write_reg(REG_ZONE_ROW_START, rs);
    write_reg(REG_ZONE_ROW_END, re);
    write_reg(REG_ZONE_COL_START, cs);
    write_reg(REG_ZONE_COL_END, ce);
    cfg_we <= 1'b0;
  endtask

  task automatic zone_bounds(input int mode, output logic [BOUND_W-1:0] lo,
                             output logic [BOUND_W-1:0] hi);
    int unsigned first;
    first = $urandom_range(1023);
    case (mode)
      0: begin
        lo = '0;
        hi = 11'd1024;
      end
      1: begin
        lo = {1'($urandom), 10'(first)};
        hi = 11'(first + $urandom_range(48, 1));
      end
      2: begin
        lo = BOUND_W'($urandom);
        hi = BOUND_W'($urandom);
      end
      default: begin
        lo = {1'($urandom), 10'($urandom_range(1023, 900))};
        hi = ($urandom_range(1) != 0) ? 11'd1024 : 11'd2047;
      end
    endcase
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] lo,
                                                    input logic [BOUND_W-1:0] hi);
    int unsigned top;
    top = (hi > 11'd1024) ? 1024 : int'(hi);
    if ($urandom_range(9) < 8 && int'(lo) < top) return COORD_W'($urandom_range(top - 1, lo));
    return COORD_W'($urandom);
  endfunction

  function automatic pixel_t zone_pixel(input logic last, input bit black);
    pixel_t px;
    px.row = pick_coord(zr_start, zr_end);
    px.col = pick_coord(zc_start, zc_end);
    px.value = black ? 8'd0 : 8'($urandom_range(255, 1));
    px.last = last;
    return px;
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_tready <= !recv_idle || $urandom_range(99) >= 34;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        $error("unexpected result: mean_distance %0d, black_count %0d", got.mean, got.count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.mean !== want.mean) begin
          $error("mean_distance: expected %0d, actual %0d", want.mean, got.mean);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $error("black_count: expected %0d, actual %0d", want.count, got.count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    directed_t   dir_tab[20];
    pixel_t      px;
    int          quota;
    int          n;
    bit          broken;
    logic [BOUND_W-1:0] rs, re, cs, ce;
    dir_tab = '{
      // reset zone 0..9, centroid at origin
      '{1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 0, 1},
      '{1'b0, 0, 0, 0, 0, 0, 0, 3, 4, 0, 1'b1, 1'b1, 1280, 1},
      '{1'b0, 0, 0, 0, 0, 0, 0, 3, 4, 1, 1'b1, 1'b1, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 10, 0, 0, 1'b1, 1'b1, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 0, 10, 0, 1'b1, 1'b1, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 9, 9, 0, 1'b0, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 3, 4, 255, 1'b0, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0, 0},
      // whole image, centroid in the far corner
      '{1'b1, 2047, 2047, 0, 1024, 0, 1024, 0, 0, 0, 1'b1, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 1023, 1023, 0, 1'b1, 1'b1, 0, 1},
      '{1'b0, 0, 0, 0, 0, 0, 0, 1023, 0, 0, 1'b0, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 0, 1023, 0, 1'b0, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 512, 512, 128, 1'b0, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 1023, 1023, 0, 1'b1, 1'b0, 0, 0},
      // empty zone: start equal to end, then start above end
      '{1'b1, 0, 0, 100, 100, 0, 1024, 100, 5, 0, 1'b1, 1'b1, 0, 0},
      '{1'b1, 0, 0, 0, 1024, 600, 500, 0, 550, 0, 1'b1, 1'b1, 0, 0},
      // row bound past the image, one column wide
      '{1'b1, 512, 300, 500, 2047, 1023, 1024, 1023, 1023, 0, 1'b0, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 499, 1023, 0, 1'b0, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 500, 1023, 0, 1'b1, 1'b0, 0, 0},
      '{1'b0, 0, 0, 0, 0, 0, 0, 600, 1022, 0, 1'b1, 1'b1, 0, 0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].reconf) begin
        drain_results();
        load_config(dir_tab[i].cr, dir_tab[i].cc, dir_tab[i].rs, dir_tab[i].re,
                    dir_tab[i].cs, dir_tab[i].ce);
      end
      px = '{dir_tab[i].row, dir_tab[i].col, dir_tab[i].value, dir_tab[i].last};
      issue_pixel(px);
      if (dir_tab[i].typed && dir_tab[i].last)
        pending_results[$] = '{dir_tab[i].count, dir_tab[i].mean};
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      zone_bounds((ph == 2) ? 0 : $urandom_range(3), rs, re);
      zone_bounds((ph == 2) ? 0 : $urandom_range(3), cs, ce);
      load_config(BOUND_W'($urandom), BOUND_W'($urandom), rs, re, cs, ce);
      send_idle = (ph != 4);
      recv_idle = (ph != 4);
      if (ph == 2) begin
        // hold the receiver off and keep offering single-pixel scans
        hold_left = HOLD_CYCLES;
        send_idle = 1'b0;
        for (int k = 0; k < 15; k++) begin
          issue_pixel(zone_pixel(1'b1, 1'b1));
        end
        send_idle = 1'b1;
      end
      quota = 0;
      while (quota < PHASE_ITEMS) begin
        if ($urandom_range(19) == 0) begin
          px = pixel_t'($urandom);
          issue_pixel(px);
          quota++;
        end else begin
          n = $urandom_range(12, 1);
          broken = $urandom_range(9) == 0;
          for (int k = 0; k < n; k++) begin
            issue_pixel(zone_pixel(k == n - 1 && !broken, $urandom_range(9) < 6));
            quota++;
          end
        end
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
